/* sv/lmpc_pkg.sv */
package lmpc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int REG_W = 24;
    localparam int RHO_IN_W = 24;
    localparam int THETA_W = 16;
    localparam int RHO_OUT_W = 32;

    // cordic datapath width (angles and vectors in 2^-30 units)
    localparam int CW = 36;
    // vectoring datapath width (normalized to 2^52..2^53)
    localparam int VW = 58;

    localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam int THETA_LIMIT = 25736;

    // register indexes
    localparam logic [1:0] REG_FOCAL_X = 2'd0;
    localparam logic [1:0] REG_FOCAL_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_U = 2'd2;
    localparam logic [1:0] REG_CENTER_V = 2'd3;

    typedef struct packed {
        logic [REG_W-1:0] focal_x;
        logic [REG_W-1:0] focal_y;
        logic [REG_W-1:0] center_u;
        logic [REG_W-1:0] center_v;
    } cfg_t;

    function automatic logic signed [CW-1:0] atan_entry(input int i);
        logic signed [CW-1:0] t;
        case (i)
            0: t = 36'sh03243F6A8;
            1: t = 36'sh01DAC6705;
            2: t = 36'sh00FADBAFC;
            3: t = 36'sh007F56EA6;
            4: t = 36'sh003FEAB76;
            5: t = 36'sh001FFD55B;
            6: t = 36'sh000FFFAAA;
            7: t = 36'sh0007FFF55;
            8: t = 36'sh0003FFFEA;
            9: t = 36'sh0001FFFFD;
            10: t = 36'sh0000FFFFF;
            11: t = 36'sh00007FFFF;
            12: t = 36'sh00003FFFF;
            13: t = 36'sh00001FFFF;
            14: t = 36'sh00000FFFF;
            15: t = 36'sh000007FFF;
            16: t = 36'sh000003FFF;
            17: t = 36'sh000001FFF;
            18: t = 36'sh000000FFF;
            19: t = 36'sh0000007FF;
            20: t = 36'sh0000003FF;
            21: t = 36'sh0000001FF;
            22: t = 36'sh0000000FF;
            23: t = 36'sh00000007F;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

/* sv/lmpc_rotate.sv */
// pipelined rotation cordic: one micro-rotation per stage
module lmpc_rotate #(
    parameter int STEPS = lmpc_pkg::CORDIC_STEPS,
    parameter int TW = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [lmpc_pkg::THETA_W-1:0] theta,
    input  logic [TW-1:0]                    in_tag,
    output logic                             out_valid,
    output logic signed [lmpc_pkg::CW-1:0]   cos_out,
    output logic signed [lmpc_pkg::CW-1:0]   sin_out,
    output logic [TW-1:0]                    out_tag
);
    localparam int CW = lmpc_pkg::CW;

    logic signed [CW-1:0] x_reg [STEPS+1];
    logic signed [CW-1:0] y_reg [STEPS+1];
    logic signed [CW-1:0] z_reg [STEPS+1];
    logic                 f_reg [STEPS+1];
    logic [TW-1:0]        t_reg [STEPS+1];
    logic                 v_reg [STEPS+1];

    logic signed [CW-1:0] z0;
    logic signed [CW-1:0] z_next;
    logic                 f_next;

    // fold the angle by pi into the right half plane
    always_comb begin
        z0 = CW'(theta) <<< 17;
        z_next = z0;
        f_next = 1'b0;
        if (z0 > lmpc_pkg::HALF_PI_Q30) begin
            z_next = z0 - lmpc_pkg::PI_Q30;
            f_next = 1'b1;
        end else if (z0 < -lmpc_pkg::HALF_PI_Q30) begin
            z_next = z0 + lmpc_pkg::PI_Q30;
            f_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            x_reg[0] <= lmpc_pkg::GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= z_next;
            f_reg[0] <= f_next;
            t_reg[0] <= in_tag;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                f_reg[i+1] <= f_reg[i];
                t_reg[i+1] <= t_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - lmpc_pkg::atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + lmpc_pkg::atan_entry(i);
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_tag = t_reg[STEPS];
    assign cos_out = f_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
    assign sin_out = f_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
endmodule

/* sv/lmpc_vector.sv */
// pipelined vectoring cordic with normalization, gives angle in 2^-30 rad
module lmpc_vector #(
    parameter int STEPS = lmpc_pkg::CORDIC_STEPS,
    parameter int AW = 32,
    parameter int TW = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [AW-1:0]           a_in,
    input  logic signed [AW-1:0]           b_in,
    input  logic [TW-1:0]                  in_tag,
    output logic                           out_valid,
    output logic signed [lmpc_pkg::CW-1:0] z_out,
    output logic [TW-1:0]                  out_tag
);
    localparam int VW = lmpc_pkg::VW;
    localparam int CW = lmpc_pkg::CW;
    localparam int SW = $clog2(VW);

    logic signed [VW-1:0] x_reg [STEPS+2];
    logic signed [VW-1:0] y_reg [STEPS+2];
    logic signed [CW-1:0] z_reg [STEPS+2];
    logic [TW-1:0]        t_reg [STEPS+2];
    logic                 v_reg [STEPS+2];
    logic [SW-1:0]        sh_reg;

    logic [AW-1:0]        ma, mb, mm;
    logic [SW-1:0]        sh_next;

    // shift count so the larger magnitude reaches 2^52
    always_comb begin
        ma = a_in[AW-1] ? AW'(-a_in) : AW'(a_in);
        mb = b_in[AW-1] ? AW'(-b_in) : AW'(b_in);
        mm = (mb > ma) ? mb : ma;
        sh_next = '0;
        for (int k = 0; k < AW; k++) begin
            if (mm[k]) begin
                sh_next = SW'(52 - k);
            end
        end
    end

    // stage 0 latches and shift count, stage 1 normalizes and turns half plane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
            v_reg[1] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            v_reg[1] <= v_reg[0];
        end
        if (en) begin
            x_reg[0] <= VW'(a_in);
            y_reg[0] <= VW'(b_in);
            sh_reg <= sh_next;
            t_reg[0] <= in_tag;
            t_reg[1] <= t_reg[0];
            z_reg[0] <= '0;
            if (x_reg[0] < 0) begin
                if (y_reg[0] >= 0) begin
                    x_reg[1] <= y_reg[0] <<< sh_reg;
                    y_reg[1] <= -(x_reg[0] <<< sh_reg);
                    z_reg[1] <= lmpc_pkg::HALF_PI_Q30;
                end else begin
                    x_reg[1] <= -(y_reg[0] <<< sh_reg);
                    y_reg[1] <= x_reg[0] <<< sh_reg;
                    z_reg[1] <= -lmpc_pkg::HALF_PI_Q30;
                end
            end else begin
                x_reg[1] <= x_reg[0] <<< sh_reg;
                y_reg[1] <= y_reg[0] <<< sh_reg;
                z_reg[1] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+2] <= 1'b0;
            end else if (en) begin
                v_reg[i+2] <= v_reg[i+1];
            end
            if (en) begin
                t_reg[i+2] <= t_reg[i+1];
                if (y_reg[i+1] >= 0) begin
                    x_reg[i+2] <= x_reg[i+1] + (y_reg[i+1] >>> i);
                    y_reg[i+2] <= y_reg[i+1] - (x_reg[i+1] >>> i);
                    z_reg[i+2] <= z_reg[i+1] + lmpc_pkg::atan_entry(i);
                end else begin
                    x_reg[i+2] <= x_reg[i+1] - (y_reg[i+1] >>> i);
                    y_reg[i+2] <= y_reg[i+1] + (x_reg[i+1] >>> i);
                    z_reg[i+2] <= z_reg[i+1] - lmpc_pkg::atan_entry(i);
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS+1];
    assign out_tag = t_reg[STEPS+1];
    assign z_out = z_reg[STEPS+1];
endmodule

/* sv/lmpc_sqrt.sv */
// pipelined restoring square root, one result bit per stage
module lmpc_sqrt #(
    parameter int IW = 64,
    parameter int TW = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [IW-1:0]   radicand,
    input  logic [TW-1:0]   in_tag,
    output logic            out_valid,
    output logic [IW/2-1:0] root,
    output logic [TW-1:0]   out_tag
);
    localparam int RW = IW / 2;

    logic [IW-1:0] rem_reg [RW+1];
    logic [RW-1:0] q_reg   [RW+1];
    logic [TW-1:0] t_reg   [RW+1];
    logic          v_reg   [RW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            rem_reg[0] <= radicand;
            q_reg[0] <= '0;
            t_reg[0] <= in_tag;
        end
    end

    for (genvar i = 0; i < RW; i++) begin : g_bit
        localparam int B = RW - 1 - i;
        logic [IW-1:0] trial;
        assign trial = (IW'(q_reg[i]) << (B + 1)) | (IW'(1) << (2 * B));
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                t_reg[i+1] <= t_reg[i];
                if (rem_reg[i] >= trial) begin
                    rem_reg[i+1] <= rem_reg[i] - trial;
                    q_reg[i+1] <= q_reg[i] | (RW'(1) << B);
                end else begin
                    rem_reg[i+1] <= rem_reg[i];
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign root = q_reg[RW];
    assign out_tag = t_reg[RW];
endmodule

/* sv/lmpc_divide.sv */
// pipelined restoring divider with round half up on magnitudes
module lmpc_divide #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int TW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [NW-1:0] quot,
    output logic [TW-1:0] out_tag
);
    localparam int RW = DW + 1;

    logic [NW-1:0] n_reg [NW+1];
    logic [RW-1:0] r_reg [NW+1];
    logic [DW-1:0] d_reg [NW+1];
    logic [TW-1:0] t_reg [NW+1];
    logic          v_reg [NW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            n_reg[0] <= numer + NW'(denom >> 1);
            r_reg[0] <= '0;
            d_reg[0] <= denom;
            t_reg[0] <= in_tag;
        end
    end

    // numerator shifts out as quotient shifts in
    for (genvar i = 0; i < NW; i++) begin : g_bit
        logic [RW:0] sh;
        assign sh = {r_reg[i], n_reg[i][NW-1]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                d_reg[i+1] <= d_reg[i];
                t_reg[i+1] <= t_reg[i];
                if (sh >= (RW+1)'(d_reg[i])) begin
                    r_reg[i+1] <= RW'(sh - (RW+1)'(d_reg[i]));
                    n_reg[i+1] <= {n_reg[i][NW-2:0], 1'b1};
                end else begin
                    r_reg[i+1] <= RW'(sh);
                    n_reg[i+1] <= {n_reg[i][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[NW];
    assign quot = n_reg[NW];
    assign out_tag = t_reg[NW];
endmodule

/* sv/line_meter_to_pixel_conversion_unit.sv */
// Line conversion from normalized image plane to pixel polar form.
// Input word on s_axis (s_tvalid/s_tready/s_tdata): rho_meter Q3.20 in bits
// 23:0, theta_meter Q3.13 in bits 39:24. Result word on m_axis: rho_pixel
// Q24.8 in bits 31:0, theta_pixel Q3.13 in bits 47:32, divide_error in bit 48.
// Intrinsics are written through cfg_we/cfg_addr/cfg_wdata; the user must
// do so only while idle, as the block does not enforce it. Throughput is
// one word per cycle unless stalled; the longest chain is (CORDIC_STEPS+1)
// rotation + 4 scaling and numerator + 33 square root + 65 divide + 1 output
// stages; the vectoring cordic runs beside the root and divide, delay matched.
// The whole pipeline advances together; when m_tready is low and the output
// register is full, everything holds and s_tready drops, so no word is lost
// or repeated. Reset clears all valid bits and loads the default intrinsics
// (focal 600.0, center 320.0/240.0). A zero denominator gives divide_error
// with zero rho_pixel and theta_pixel.
module line_meter_to_pixel_conversion_unit #(
    parameter int CORDIC_STEPS = lmpc_pkg::CORDIC_STEPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rho_meter[23:0], theta_meter[39:24]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // rho_pixel[31:0], theta_pixel[47:32], divide_error[48]
    output logic [55:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);
    localparam int CW = lmpc_pkg::CW;
    localparam int RW = lmpc_pkg::REG_W;
    localparam int AW = 32;
    localparam int NW = 64;
    localparam int TW = RW;

    lmpc_pkg::cfg_t cfg_reg;

    logic en;
    logic out_valid_reg;
    logic [55:0] out_data_reg;

    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.focal_x <= 24'd153600;
            cfg_reg.focal_y <= 24'd153600;
            cfg_reg.center_u <= 24'd81920;
            cfg_reg.center_v <= 24'd61440;
        end else if (cfg_we) begin
            case (cfg_addr)
                lmpc_pkg::REG_FOCAL_X: cfg_reg.focal_x <= cfg_wdata;
                lmpc_pkg::REG_FOCAL_Y: cfg_reg.focal_y <= cfg_wdata;
                lmpc_pkg::REG_CENTER_U: cfg_reg.center_u <= cfg_wdata;
                lmpc_pkg::REG_CENTER_V: cfg_reg.center_v <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // rotation cordic, rho travels along as tag
    logic rot_valid;
    logic signed [CW-1:0] cos_w, sin_w;
    logic [TW-1:0] rot_rho;

    lmpc_rotate #(.STEPS(CORDIC_STEPS), .TW(TW)) u_rotate (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid && en),
        .theta(s_tdata[39:24]),
        .in_tag(s_tdata[23:0]),
        .out_valid(rot_valid), .cos_out(cos_w), .sin_out(sin_w),
        .out_tag(rot_rho)
    );

    // scaling: product stage then shift stage
    logic signed [CW+RW:0] pa_reg, pb_reg;
    logic signed [RW:0]    rho1_reg;
    logic                  v1_reg, v2_reg;
    logic signed [AW-1:0]  a_reg, b_reg;
    logic [2*RW-1:0]       fxy_reg;
    logic signed [RW-1:0]  rho2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= rot_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            pa_reg <= $signed({1'b0, cfg_reg.focal_y}) * cos_w;
            pb_reg <= $signed({1'b0, cfg_reg.focal_x}) * sin_w;
            rho1_reg <= (RW+1)'($signed(rot_rho));
            a_reg <= AW'(pa_reg >>> 24);
            b_reg <= AW'(pb_reg >>> 24);
            fxy_reg <= cfg_reg.focal_x * cfg_reg.focal_y;
            rho2_reg <= RW'(rho1_reg);
        end
    end

    // numerator terms and sum of squares
    logic signed [NW-1:0] t1_reg, t2_reg, t3_reg;
    logic [NW-1:0]        aa_reg, bb_reg;
    logic                 v3_reg, v4_reg;
    logic signed [AW-1:0] a3_reg, b3_reg, a4_reg, b4_reg;
    logic signed [NW-1:0] n_reg;
    logic [NW-1:0]        ss_reg;
    logic [AW-1:0]        ma, mb;

    assign ma = a_reg[AW-1] ? AW'(-a_reg) : AW'(a_reg);
    assign mb = b_reg[AW-1] ? AW'(-b_reg) : AW'(b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
        if (en) begin
            t1_reg <= NW'($signed({1'b0, fxy_reg[2*RW-1:10]})) * NW'(rho2_reg);
            t2_reg <= NW'($signed({1'b0, cfg_reg.center_u})) * NW'(a_reg);
            t3_reg <= NW'($signed({1'b0, cfg_reg.center_v})) * NW'(b_reg);
            aa_reg <= NW'(ma) * NW'(ma);
            bb_reg <= NW'(mb) * NW'(mb);
            a3_reg <= a_reg;
            b3_reg <= b_reg;
            n_reg <= (t1_reg >>> 4) + t2_reg + t3_reg;
            ss_reg <= aa_reg + bb_reg;
            a4_reg <= a3_reg;
            b4_reg <= b3_reg;
        end
    end

    // vectoring cordic on (a, b)
    logic vec_valid;
    logic signed [CW-1:0] z_w;
    logic unused_tag;

    lmpc_vector #(.STEPS(CORDIC_STEPS), .AW(AW), .TW(1)) u_vector (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v4_reg), .a_in(a4_reg), .b_in(b4_reg), .in_tag(1'b0),
        .out_valid(vec_valid), .z_out(z_w), .out_tag(unused_tag)
    );

    // square root of a^2 + b^2, numerator sign and magnitude ride along
    logic sq_valid;
    logic [NW/2-1:0] d_w;
    logic [NW:0] sq_tag;
    logic [NW-1:0] nmag;

    assign nmag = n_reg[NW-1] ? NW'(-n_reg) : NW'(n_reg);

    lmpc_sqrt #(.IW(NW), .TW(NW+1)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v4_reg), .radicand(ss_reg), .in_tag({n_reg[NW-1], nmag}),
        .out_valid(sq_valid), .root(d_w), .out_tag(sq_tag)
    );

    // theta delay line to match root and divide latency
    localparam int VLAT = CORDIC_STEPS + 2;
    localparam int DLAT = NW / 2 + 1 + NW + 1;
    localparam int GAP = DLAT - VLAT;
    localparam int AGAP = NW / 2 + 1 - VLAT;

    logic signed [lmpc_pkg::THETA_W-1:0] th_w;
    logic signed [CW-1:0] th_full;

    assign th_full = (z_w + CW'(65536)) >>> 17;
    always_comb begin
        if (th_full > CW'(lmpc_pkg::THETA_LIMIT)) begin
            th_w = 16'(lmpc_pkg::THETA_LIMIT);
        end else if (th_full < -CW'(lmpc_pkg::THETA_LIMIT)) begin
            th_w = -16'(lmpc_pkg::THETA_LIMIT);
        end else begin
            th_w = th_full[15:0];
        end
    end

    logic [15:0] thd_reg [GAP];
    always_ff @(posedge aclk) begin
        if (en) begin
            thd_reg[0] <= th_w;
            for (int k = 1; k < GAP; k++) begin
                thd_reg[k] <= thd_reg[k-1];
            end
        end
    end

    // divide, tag carries sign and zero flag
    logic dv_valid;
    logic [NW-1:0] q_w;
    logic [1:0] dv_tag;

    lmpc_divide #(.NW(NW), .DW(NW/2), .TW(2)) u_divide (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sq_valid), .numer(sq_tag[NW-1:0]),
        .denom((d_w == '0) ? (NW/2)'(1) : d_w),
        .in_tag({sq_tag[NW], d_w == '0}),
        .out_valid(dv_valid), .quot(q_w), .out_tag(dv_tag)
    );

    // saturate and output register
    logic signed [31:0] rp;
    always_comb begin
        if (dv_tag[1]) begin
            rp = (q_w > NW'(64'd2147483648)) ? 32'sh80000000 : 32'(-q_w);
        end else begin
            rp = (q_w > NW'(64'd2147483647)) ? 32'sh7FFFFFFF : 32'(q_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid;
        end
        if (en) begin
            if (dv_tag[0]) begin
                out_data_reg <= {7'd0, 1'b1, 16'd0, 32'd0};
            end else begin
                out_data_reg <= {7'd0, 1'b0, thd_reg[GAP-1], rp};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // vectoring valid delayed to the root output for the alignment check
    logic v_align_chk;
    logic vq_reg [AGAP];
    assign v_align_chk = vq_reg[AGAP-1];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < AGAP; k++) begin
                vq_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vq_reg[0] <= vec_valid;
            for (int k = 1; k < AGAP; k++) begin
                vq_reg[k] <= vq_reg[k-1];
            end
        end
    end

    // stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed under stall");
    // error words carry zero payload
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[48] |-> m_tdata[47:0] == 48'd0)
        else $error("error word with nonzero payload");
    // root and vectoring paths stay aligned
    a_align: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_valid == v_align_chk)
        else $error("pipeline misaligned");
    // ready follows output occupancy
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("ready low with empty output");
endmodule
